FILE: hdl/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants for the regret matching self-play core.
// ----------------------------------------------------------------------------
package rms_pkg;
  localparam int ACTION_COUNT = 3;
  localparam logic [16:0] ONE_FIX = 17'd65536;
  localparam logic [16:0] THIRD_FIX = 17'd21845;
  localparam logic [47:0] ST_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [1:0] MOVE_ROCK = 2'd0;
  localparam logic [1:0] MOVE_PAPER = 2'd1;
  localparam logic [1:0] MOVE_SCISSORS = 2'd2;

  typedef logic [16:0] prob_t;

  // divider handshake: start a quotient, report done
  typedef struct packed {
    logic start;
    logic [65:0] num;
    logic [49:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [16:0] quot;
  } div_rsp_t;
endpackage

FILE: hdl/rms_divider.sv
// ----------------------------------------------------------------------------
// rms_divider
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// Caller guarantees quotient fits in 17 bits (num <= den * 65536).
// ----------------------------------------------------------------------------
module rms_divider (
  input  logic              clk,
  input  logic              rst,
  input  rms_pkg::div_req_t req,
  output rms_pkg::div_rsp_t rsp
);
  import rms_pkg::*;

  logic [65:0] num;
  logic [49:0] den;
  logic [50:0] rem;
  logic [16:0] quot;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [50:0] trial;
  logic [50:0] shifted;

  // each quotient bit compares the remainder, shifted left with the next numerator bit, against den; MSB first
  always_comb begin
    shifted = {rem[49:0], num[65]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == 5'd16);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        if (cnt == 5'd16) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

  // numerator up to 66 bits: shift through all leading bits in first pass
  // by preloading rem with num >> 16, then 17 steps produce quotient.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.num[65:16]};
      num  <= {req.num[15:0], 50'd0};
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      if (cnt != 5'd0) begin
        if (!trial[50]) begin
          rem  <= trial;
          quot <= {quot[15:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[15:0], 1'b0};
        end
        num <= {num[64:0], 1'b0};
      end else begin
        // first step: quotient MSB from preloaded remainder
        if (rem >= {1'b0, den}) begin
          rem  <= rem - {1'b0, den};
          quot <= 17'd1;
        end
      end
    end
  end

  assign rsp = '{done: done, quot: quot};
endmodule

FILE: hdl/regret_matching_selfplay_core.sv
// ----------------------------------------------------------------------------
// regret_matching_selfplay_core
// Regret matching self-play for rock-paper-scissors, one iteration per beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with rand_mine, rand_opp. Output channel:
// out_valid/out_stall with moves, current strategy, average strategy,
// avg_valid and iterations_done.
// One beat in, one beat out. An iteration runs six divisions on a single
// shared restoring divider, each one a start, 17 quotient steps and done:
// three for the current strategy (skipped when no regret is positive) and
// three for the average, plus an update state. out_valid rises once the
// last average division is done. in_stall stays high for the whole
// iteration.
// The result sits in the output registers until taken; a new beat is only
// accepted once the output is free, since regrets carry to the next item.
// Synchronous reset clears regrets, strategy totals and the count.
// ----------------------------------------------------------------------------
module regret_matching_selfplay_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] rand_mine,
  input  logic [15:0] rand_opp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  my_move,
  output logic [1:0]  opponent_move,
  output logic [16:0] prob_rock,
  output logic [16:0] prob_paper,
  output logic [16:0] prob_scissors,
  output logic [16:0] avg_rock,
  output logic [16:0] avg_paper,
  output logic [16:0] avg_scissors,
  output logic        avg_valid,
  output logic [31:0] iterations_done
);
  import rms_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PDIV  = 7'b0000010,
    S_PWAIT = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_ADIV  = 7'b0010000,
    S_AWAIT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic signed [31:0] regret [ACTION_COUNT];
  logic [47:0] strat [ACTION_COUNT];
  logic [31:0] count;
  logic [15:0] r_mine, r_opp;
  prob_t p [ACTION_COUNT];
  prob_t avg [ACTION_COUNT];
  logic [1:0] idx;
  logic [33:0] psum;
  logic [49:0] tot;
  logic [31:0] pos [ACTION_COUNT];
  logic [1:0] mine, opp;
  logic [17:0] cum0, cum01;

  div_req_t dreq;
  div_rsp_t drsp;

  rms_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    for (int a = 0; a < ACTION_COUNT; a++)
      pos[a] = regret[a][31] ? 32'd0 : regret[a];
    psum = {2'b0, pos[0]} + {2'b0, pos[1]} + {2'b0, pos[2]};
    tot  = {2'b0, strat[0]} + {2'b0, strat[1]} + {2'b0, strat[2]};
    cum0  = {1'b0, p[0]};
    cum01 = {1'b0, p[0]} + {1'b0, p[1]};
    mine = ({2'b0, r_mine} < cum0) ? MOVE_ROCK :
           ({2'b0, r_mine} < cum01) ? MOVE_PAPER : MOVE_SCISSORS;
    opp  = ({2'b0, r_opp} < cum0) ? MOVE_ROCK :
           ({2'b0, r_opp} < cum01) ? MOVE_PAPER : MOVE_SCISSORS;
    dreq.start = (state == S_PDIV) || (state == S_ADIV);
    if (state == S_PDIV) begin
      dreq.num = {18'd0, pos[idx], 16'd0};
      dreq.den = {16'd0, psum};
    end else begin
      dreq.num = {2'b0, strat[idx], 16'd0};
      dreq.den = tot;
    end
  end

  // utility of move a against opp, cyclic around opp; the update takes util(a)-util(mine)
  function automatic logic signed [2:0] util(input logic [1:0] a, input logic [1:0] o);
    logic [1:0] d;
    d = (a >= o) ? a - o : a + 2'd3 - o;
    case (d)
      2'd0:    util = 3'sd0;
      2'd1:    util = 3'sd1;
      default: util = -3'sd1;
    endcase
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      for (int a = 0; a < ACTION_COUNT; a++) begin
        regret[a] <= '0;
        strat[a]  <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          r_mine <= rand_mine;
          r_opp  <= rand_opp;
          idx    <= 2'd0;
          if (psum == 34'd0) begin
            for (int a = 0; a < ACTION_COUNT; a++) p[a] <= THIRD_FIX;
            state <= S_UPD;
          end else begin
            state <= S_PDIV;
          end
        end
        S_PDIV: state <= S_PWAIT;
        S_PWAIT: if (drsp.done) begin
          p[idx] <= drsp.quot;
          if (idx == 2'd2) state <= S_UPD;
          else begin
            idx   <= idx + 2'd1;
            state <= S_PDIV;
          end
        end
        S_UPD: begin
          for (int a = 0; a < ACTION_COUNT; a++) begin
            logic [48:0] s;
            logic signed [32:0] g;
            s = {1'b0, strat[a]} + {32'd0, p[a]};
            strat[a] <= s[48] ? ST_MAX : s[47:0];
            g = {regret[a][31], regret[a]} +
                33'(util(2'(a), opp) - util(mine, opp));
            if (g > 33'sh0_7FFF_FFFF) regret[a] <= 32'sh7FFF_FFFF;
            else if (g < -33'sh0_8000_0000) regret[a] <= 32'sh8000_0000;
            else regret[a] <= g[31:0];
          end
          my_move       <= mine;
          opponent_move <= opp;
          if (count != 32'hFFFF_FFFF) count <= count + 32'd1;
          idx   <= 2'd0;
          state <= S_ADIV;
        end
        S_ADIV: state <= S_AWAIT;
        S_AWAIT: if (drsp.done) begin
          avg[idx] <= drsp.quot;
          if (idx == 2'd2) state <= S_OUT;
          else begin
            idx   <= idx + 2'd1;
            state <= S_ADIV;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign prob_rock       = p[0];
  assign prob_paper      = p[1];
  assign prob_scissors   = p[2];
  assign avg_rock        = avg[0];
  assign avg_paper       = avg[1];
  assign avg_scissors    = avg[2];
  assign avg_valid       = 1'b1;
  assign iterations_done = count;
endmodule

FILE: tb/regret_matching_selfplay_core_test.sv
// ----------------------------------------------------------------------------
// regret_matching_selfplay_core_test
// Drives self-play iterations into the core and checks every result beat
// against an in-bench model of regret matching, under varied idling.
// ----------------------------------------------------------------------------
module regret_matching_selfplay_core_test;
  import rms_pkg::*;

  typedef struct packed {
    logic [1:0]  mine;
    logic [1:0]  opp;
    logic [16:0] pr, pp, ps;
    logic [16:0] ar, ap, as_;
    logic        av;
    logic [31:0] iters;
  } rms_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] rand_mine = '0;
  logic [15:0] rand_opp = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  my_move, opponent_move;
  logic [16:0] prob_rock, prob_paper, prob_scissors;
  logic [16:0] avg_rock, avg_paper, avg_scissors;
  logic        avg_valid;
  logic [31:0] iterations_done;

  regret_matching_selfplay_core dut (.*);

  always #6 clk = ~clk;

  // model state
  logic signed [31:0] regret [3];
  logic [47:0]        strat_sum [3];
  logic [31:0]        iter_cnt;

  rms_result_t pending_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  function automatic logic [1:0] draw_move(logic [16:0] p0, logic [16:0] p1,
                                           logic [15:0] r);
    if ({1'b0, r} < p0) return MOVE_ROCK;
    if ({2'b0, r} < ({1'b0, p0} + {1'b0, p1})) return MOVE_PAPER;
    return MOVE_SCISSORS;
  endfunction

  function automatic logic signed [31:0] sat_regret(logic signed [31:0] x,
                                                    int d);
    longint s;
    s = longint'(x) + d;
    if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  task automatic iterate_model(logic [15:0] rm, logic [15:0] ro);
    logic [63:0] pos [3];
    logic [63:0] psum, tot, t;
    logic [16:0] p [3];
    int util [3];
    rms_result_t r;
    psum = 0;
    tot = 0;
    for (int a = 0; a < 3; a++) begin
      pos[a] = (regret[a] > 0) ? 64'(regret[a]) : 64'd0;
      psum += pos[a];
    end
    for (int a = 0; a < 3; a++) begin
      p[a] = (psum != 0) ? 17'((pos[a] * 64'd65536) / psum) : THIRD_FIX;
      t = {16'd0, strat_sum[a]} + p[a];
      strat_sum[a] = (t > {16'd0, ST_MAX}) ? ST_MAX : t[47:0];
    end
    r.mine = draw_move(p[0], p[1], rm);
    r.opp = draw_move(p[0], p[1], ro);
    util[r.opp] = 0;
    util[(r.opp + 1) % 3] = 1;
    util[(r.opp + 2) % 3] = -1;
    for (int a = 0; a < 3; a++)
      regret[a] = sat_regret(regret[a], util[a] - util[r.mine]);
    if (iter_cnt != 32'hFFFFFFFF) iter_cnt++;
    for (int a = 0; a < 3; a++) tot += strat_sum[a];
    // 48-bit sum times 2^16 fits in 66 bits; use 128-bit math
    r.ar = (tot != 0) ? 17'(({80'd0, strat_sum[0]} << 16) / {64'd0, tot}) : '0;
    r.ap = (tot != 0) ? 17'(({80'd0, strat_sum[1]} << 16) / {64'd0, tot}) : '0;
    r.as_ = (tot != 0) ? 17'(({80'd0, strat_sum[2]} << 16) / {64'd0, tot}) : '0;
    r.pr = p[0];
    r.pp = p[1];
    r.ps = p[2];
    r.av = (tot != 0);
    r.iters = iter_cnt;
    pending_q.push_back(r);
  endtask

  // valid stays up after a beat is taken until the next beat or an idle cycle
  task automatic send_iteration(logic [15:0] rm, logic [15:0] ro);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rand_mine <= rm;
    rand_opp <= ro;
    iterate_model(rm, ro);
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("regret_matching_selfplay_core_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        rms_result_t got, want;
        got = '{my_move, opponent_move, prob_rock, prob_paper, prob_scissors,
                avg_rock, avg_paper, avg_scissors, avg_valid, iterations_done};
        results_seen++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at iteration %0d\n  exp %p\n  got %p",
                       want.iters, want, got);
          end
        end
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned s, int unsigned r);
    send_idle_pct = s;
    stall_pct = r;
  endtask

  // uniform start, range extremes, then one-sided play to force positive regrets
  task automatic test_directed();
    send_iteration(16'h0000, 16'h0000);
    send_iteration(16'hFFFF, 16'hFFFF);
    send_iteration(16'd21844, 16'd21845);
    send_iteration(16'd43690, 16'd43689);
    send_iteration(16'h5555, 16'hAAAA);
    send_iteration(16'hAAAA, 16'h5555);
    for (int i = 0; i < 8; i++) send_iteration(16'h0000, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_iteration(16'hFFFF, 16'h0000);
    drain();
  endtask

  task automatic test_random(int n, int unsigned s, int unsigned r);
    set_idling(s, r);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_iteration(16'($urandom), 16'($urandom));
        1: send_iteration(16'($urandom_range(3)) * 16'h5555 - 16'($urandom_range(1)),
                          16'($urandom));
        default: send_iteration(16'($urandom), 16'($urandom_range(65535)));
      endcase
    end
    drain();
  endtask

  initial begin
    for (int a = 0; a < 3; a++) begin
      regret[a] = 0;
      strat_sum[a] = 0;
    end
    iter_cnt = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200, 0, 0);
    test_random(150, 86, 0);
    test_random(150, 0, 86);
    test_random(150, 30, 30);
    $display("sent %0d iterations, checked %0d result beats, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("covered uniform and normalized strategies, all moves, idle and stall phases");
    if (mismatches == 0 && pending_q.size() == 0)
      $display("regret_matching_selfplay_core_test: done, clean");
    else
      $display("regret_matching_selfplay_core_test: done, errors");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/rms_pkg.sv
hdl/rms_divider.sv
hdl/regret_matching_selfplay_core.sv
tb/regret_matching_selfplay_core_test.sv
